>>> hdl/fbcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbcr_pkg: shared types and constants
// Register indexes, field widths and the result item layout for the
// framed base64 checksum receiver.
// ----------------------------------------------------------------------------
package fbcr_pkg;

  localparam int BYTE_W    = 8;
  localparam int CHAR_W    = 6;
  localparam int SUM_W     = 12;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd2;

  localparam logic [BYTE_W-1:0] START_RST  = 8'd35;
  localparam logic [BYTE_W-1:0] STOP_RST   = 8'd13;
  localparam logic [BYTE_W-1:0] OFFSET_RST = 8'd61;

  // header_pos codes
  localparam logic [1:0] HDR_ADDR = 2'd0;
  localparam logic [1:0] HDR_CMD  = 2'd1;
  localparam logic [1:0] HDR_DONE = 2'd2;

  // lag_fill / group_fill limits
  localparam logic [1:0] LAG_FULL   = 2'd2;
  localparam logic [1:0] GROUP_LAST = 2'd3;

  typedef struct packed {
    logic              frame_end;
    logic [BYTE_W-1:0] data_first;
    logic [BYTE_W-1:0] data_second;
    logic [BYTE_W-1:0] data_third;
    logic [BYTE_W-1:0] frame_address;
    logic [BYTE_W-1:0] frame_command;
    logic              check_ok;
  } result_t;

  // sign-extend a line byte into the checksum width
  function automatic logic [SUM_W-1:0] sext_byte(input logic [BYTE_W-1:0] b);
    sext_byte = {{(SUM_W-BYTE_W){b[BYTE_W-1]}}, b};
  endfunction

endpackage

>>> hdl/framed_base64_checksum_receiver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// framed_base64_checksum_receiver
// Frame parser for offset base64 payloads with a 12-bit additive checksum.
// ----------------------------------------------------------------------------
// Each result item is registered into head, or into skid while head is held.
// One byte per cycle unless in_stall; frame state updates in a single pass.
// A two-entry output buffer (head + skid) lets input run while out is stalled;
// in_stall rises only when both entries hold results.
// Reset (rst_n low, synchronous): config back to defaults, idle, buffer empty.
module framed_base64_checksum_receiver (
  input  logic       clk,
  input  logic       rst_n,
  // config
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_frame_end,
  output logic [7:0] out_data_first,
  output logic [7:0] out_data_second,
  output logic [7:0] out_data_third,
  output logic [7:0] out_frame_address,
  output logic [7:0] out_frame_command,
  output logic       out_check_ok
);

  logic [7:0] start_char_r, stop_char_r, offset_char_r;

  logic       in_frame_r,   in_frame_nxt;
  logic [1:0] header_pos_r, header_pos_nxt;
  logic [7:0] address_r,    address_nxt;
  logic [7:0] command_r,    command_nxt;
  logic [7:0] lag0_r,       lag0_nxt;
  logic [7:0] lag1_r,       lag1_nxt;
  logic [1:0] lag_fill_r,   lag_fill_nxt;
  logic [11:0] sum_r,       sum_nxt;
  logic [5:0] grp0_r,       grp0_nxt;
  logic [5:0] grp1_r,       grp1_nxt;
  logic [5:0] grp2_r,       grp2_nxt;
  logic [1:0] grp_fill_r,   grp_fill_nxt;

  fbcr_pkg::result_t res, head_r, skid_r;
  logic              res_valid;
  logic              head_valid_r, skid_valid_r;

  logic       accept, pop, push;
  logic [7:0] b, oldest, hi_exp, lo_exp, ch_byte;
  logic [5:0] ch;

  assign b      = in_rx_byte;
  assign accept = in_valid && !in_stall;
  assign pop    = head_valid_r && !out_stall;
  assign push   = accept && res_valid;

  assign in_stall = skid_valid_r;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_char_r  <= fbcr_pkg::START_RST;
      stop_char_r   <= fbcr_pkg::STOP_RST;
      offset_char_r <= fbcr_pkg::OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fbcr_pkg::CFG_START:  start_char_r  <= cfg_wdata;
        fbcr_pkg::CFG_STOP:   stop_char_r   <= cfg_wdata;
        fbcr_pkg::CFG_OFFSET: offset_char_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign oldest  = lag0_r;
  assign ch_byte = oldest - offset_char_r;
  assign ch      = ch_byte[5:0];
  assign hi_exp  = offset_char_r + {2'b00, sum_r[11:6]};
  assign lo_exp  = offset_char_r + {2'b00, sum_r[5:0]};

  // per-byte frame update
  always_comb begin
    in_frame_nxt   = in_frame_r;
    header_pos_nxt = header_pos_r;
    address_nxt    = address_r;
    command_nxt    = command_r;
    lag0_nxt       = lag0_r;
    lag1_nxt       = lag1_r;
    lag_fill_nxt   = lag_fill_r;
    sum_nxt        = sum_r;
    grp0_nxt       = grp0_r;
    grp1_nxt       = grp1_r;
    grp2_nxt       = grp2_r;
    grp_fill_nxt   = grp_fill_r;
    res            = '0;
    res_valid      = 1'b0;

    if (!in_frame_r) begin
      if (b == start_char_r) begin
        in_frame_nxt   = 1'b1;
        header_pos_nxt = fbcr_pkg::HDR_ADDR;
        address_nxt    = '0;
        command_nxt    = '0;
        lag_fill_nxt   = '0;
        grp_fill_nxt   = '0;
        sum_nxt        = fbcr_pkg::sext_byte(b);
      end
    end else if (b == stop_char_r) begin
      // stop closes the frame even if it equals start
      res_valid         = 1'b1;
      res.frame_end     = 1'b1;
      res.frame_address = address_r;
      res.frame_command = command_r;
      res.check_ok      = (header_pos_r == fbcr_pkg::HDR_DONE) &&
                          (lag_fill_r == fbcr_pkg::LAG_FULL) &&
                          (lag0_r == hi_exp) && (lag1_r == lo_exp);
      in_frame_nxt   = 1'b0;
      header_pos_nxt = fbcr_pkg::HDR_ADDR;
      address_nxt    = '0;
      command_nxt    = '0;
      lag_fill_nxt   = '0;
      grp_fill_nxt   = '0;
      sum_nxt        = '0;
    end else if (header_pos_r == fbcr_pkg::HDR_ADDR) begin
      address_nxt    = b;
      header_pos_nxt = fbcr_pkg::HDR_CMD;
      sum_nxt        = sum_r + fbcr_pkg::sext_byte(b);
    end else if (header_pos_r == fbcr_pkg::HDR_CMD) begin
      command_nxt    = b;
      header_pos_nxt = fbcr_pkg::HDR_DONE;
      sum_nxt        = sum_r + fbcr_pkg::sext_byte(b);
    end else if (lag_fill_r != fbcr_pkg::LAG_FULL) begin
      if (lag_fill_r[0]) lag1_nxt = b;
      else               lag0_nxt = b;
      lag_fill_nxt = lag_fill_r + 2'd1;
    end else begin
      // the byte leaving the lag is known to be payload
      lag0_nxt = lag1_r;
      lag1_nxt = b;
      sum_nxt  = sum_r + fbcr_pkg::sext_byte(oldest);
      unique case (grp_fill_r)
        2'd0: grp0_nxt = ch;
        2'd1: grp1_nxt = ch;
        2'd2: grp2_nxt = ch;
        default: begin
          res_valid       = 1'b1;
          res.data_first  = {grp0_r, grp1_r[5:4]};
          res.data_second = {grp1_r[3:0], grp2_r[5:2]};
          res.data_third  = {grp2_r[1:0], ch};
        end
      endcase
      grp_fill_nxt = grp_fill_r + 2'd1;  // wraps to 0 after a full group
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r   <= 1'b0;
      header_pos_r <= fbcr_pkg::HDR_ADDR;
      address_r    <= '0;
      command_r    <= '0;
      lag_fill_r   <= '0;
      sum_r        <= '0;
      grp_fill_r   <= '0;
    end else if (accept) begin
      in_frame_r   <= in_frame_nxt;
      header_pos_r <= header_pos_nxt;
      address_r    <= address_nxt;
      command_r    <= command_nxt;
      lag_fill_r   <= lag_fill_nxt;
      sum_r        <= sum_nxt;
      grp_fill_r   <= grp_fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lag0_r <= lag0_nxt;
      lag1_r <= lag1_nxt;
      grp0_r <= grp0_nxt;
      grp1_r <= grp1_nxt;
      grp2_r <= grp2_nxt;
    end
  end

  // output head register plus skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !head_valid_r) begin
      if (skid_valid_r) begin
        head_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        head_valid_r <= push;
      end
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !head_valid_r) begin
      if (skid_valid_r) head_r <= skid_r;
      else              head_r <= res;
    end else if (push) begin
      skid_r <= res;
    end
  end

  assign out_valid         = head_valid_r;
  assign out_frame_end     = head_r.frame_end;
  assign out_data_first    = head_r.data_first;
  assign out_data_second   = head_r.data_second;
  assign out_data_third    = head_r.data_third;
  assign out_frame_address = head_r.frame_address;
  assign out_frame_command = head_r.frame_command;
  assign out_check_ok      = head_r.check_ok;

  // skid only fills behind a held head
  a_skid_behind_head: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> head_valid_r)
    else $error("skid entry valid with empty head");

  a_lag_bound: assert property (@(posedge clk) disable iff (!rst_n)
    lag_fill_r != 2'd3)
    else $error("lag fill out of range");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !in_frame_r |-> (header_pos_r == fbcr_pkg::HDR_ADDR) && (lag_fill_r == '0) &&
                    (grp_fill_r == '0))
    else $error("frame counters not cleared while idle");

  a_lag_after_header: assert property (@(posedge clk) disable iff (!rst_n)
    (lag_fill_r != '0) |-> (header_pos_r == fbcr_pkg::HDR_DONE))
    else $error("payload lag filled before header complete");

  a_status_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (head_valid_r && head_r.frame_end) |->
      (head_r.data_first == '0) && (head_r.data_second == '0) && (head_r.data_third == '0))
    else $error("status item carries data bytes");

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: framed base64 checksum receiver testbench
// Feeds line bytes through the receiver: a table of hand-built frames first,
// then random frames (clean, corrupted, truncated, unterminated) mixed with
// line noise under several start/stop/offset settings. A frame decoder in the
// testbench predicts group and status items unless a table row gives its own;
// items leaving the block are matched in order against them. Sender and
// receiver idle at random; long receiver hold-offs in two passes back it up.
// ----------------------------------------------------------------------------
module tb;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int SEG_ITEMS     = 175;
  localparam int FAULT_LOG_MAX = 10;

  typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_GIVEN} row_kind_t;

  typedef struct {
    logic [fbcr_pkg::BYTE_W-1:0] rx;
    row_kind_t                   kind;
    fbcr_pkg::result_t           want;
  } line_row_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [fbcr_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [fbcr_pkg::BYTE_W-1:0]    cfg_wdata;
  logic                           in_valid;
  logic                           in_stall;
  logic [fbcr_pkg::BYTE_W-1:0]    in_rx_byte;
  logic                           out_valid;
  logic                           out_stall;
  logic                           out_frame_end;
  logic [fbcr_pkg::BYTE_W-1:0]    out_data_first;
  logic [fbcr_pkg::BYTE_W-1:0]    out_data_second;
  logic [fbcr_pkg::BYTE_W-1:0]    out_data_third;
  logic [fbcr_pkg::BYTE_W-1:0]    out_frame_address;
  logic [fbcr_pkg::BYTE_W-1:0]    out_frame_command;
  logic                           out_check_ok;

  // travels with each input item: how its outcome is known
  row_kind_t         pin_kind;
  fbcr_pkg::result_t pin_result;

  fbcr_pkg::result_t pending_q[$];
  logic [7:0]        burst_q[$];
  line_row_t         dir_rows[$];
  int                fault_count;
  int                cycle_count;
  int                send_idle_pct;
  int                recv_idle_pct;
  int                hold_requests;
  int                holds_served;
  logic [7:0]        line_start, line_stop, line_offset;

  // frame decoder state
  logic [7:0]                 cfg_open, cfg_close, cfg_base;
  logic                       fr_active;
  logic [1:0]                 fr_hdr;
  logic [7:0]                 fr_addr, fr_cmd;
  logic [7:0]                 lag_q[2];
  logic [1:0]                 lag_cnt;
  logic [fbcr_pkg::SUM_W-1:0] fr_sum;
  logic [5:0]                 grp[3];
  logic [1:0]                 grp_cnt;

  framed_base64_checksum_receiver dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_frame_end    (out_frame_end),
    .out_data_first   (out_data_first),
    .out_data_second  (out_data_second),
    .out_data_third   (out_data_third),
    .out_frame_address(out_frame_address),
    .out_frame_command(out_frame_command),
    .out_check_ok     (out_check_ok)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic logic [fbcr_pkg::SUM_W-1:0] widen(input logic [7:0] b);
    return {{(fbcr_pkg::SUM_W-8){b[7]}}, b};
  endfunction

  function automatic void drop_frame();
    fr_active = 1'b0;
    fr_hdr    = fbcr_pkg::HDR_ADDR;
    fr_addr   = '0;
    fr_cmd    = '0;
    lag_q[0]  = '0;
    lag_q[1]  = '0;
    lag_cnt   = '0;
    fr_sum    = '0;
    grp[0]    = '0;
    grp[1]    = '0;
    grp[2]    = '0;
    grp_cnt   = '0;
  endfunction

  // one line byte into the decoder; returns 1 when it yields an item
  function automatic bit decode_line_byte(input logic [7:0] b,
                                          output fbcr_pkg::result_t r);
    logic [7:0] oldest, diff, hi, lo;
    logic [5:0] ch;
    r = '0;
    if (!fr_active) begin
      if (b == cfg_open) begin
        drop_frame();
        fr_active = 1'b1;
        fr_sum    = widen(b);
      end
      return 1'b0;
    end
    // stop wins over everything inside a frame
    if (b == cfg_close) begin
      hi = cfg_base + 8'(fr_sum[11:6]);
      lo = cfg_base + 8'(fr_sum[5:0]);
      r.frame_end     = 1'b1;
      r.frame_address = fr_addr;
      r.frame_command = fr_cmd;
      r.check_ok      = (fr_hdr == fbcr_pkg::HDR_DONE) &&
                        (lag_cnt == fbcr_pkg::LAG_FULL) &&
                        (lag_q[0] == hi) && (lag_q[1] == lo);
      drop_frame();
      return 1'b1;
    end
    if (fr_hdr == fbcr_pkg::HDR_ADDR) begin
      fr_addr = b;
      fr_hdr  = fbcr_pkg::HDR_CMD;
      fr_sum  = fr_sum + widen(b);
      return 1'b0;
    end
    if (fr_hdr == fbcr_pkg::HDR_CMD) begin
      fr_cmd = b;
      fr_hdr = fbcr_pkg::HDR_DONE;
      fr_sum = fr_sum + widen(b);
      return 1'b0;
    end
    if (lag_cnt != fbcr_pkg::LAG_FULL) begin
      lag_q[lag_cnt[0]] = b;
      lag_cnt = lag_cnt + 2'd1;
      return 1'b0;
    end
    // a char only counts as payload once two newer bytes are behind it
    oldest   = lag_q[0];
    lag_q[0] = lag_q[1];
    lag_q[1] = b;
    fr_sum   = fr_sum + widen(oldest);
    diff     = oldest - cfg_base;
    ch       = diff[5:0];
    if (grp_cnt != fbcr_pkg::GROUP_LAST) begin
      grp[grp_cnt] = ch;
      grp_cnt = grp_cnt + 2'd1;
      return 1'b0;
    end
    grp_cnt       = '0;
    r.data_first  = {grp[0], grp[1][5:4]};
    r.data_second = {grp[1][3:0], grp[2][5:2]};
    r.data_third  = {grp[2][1:0], ch};
    return 1'b1;
  endfunction

  function automatic void log_fault(input string why, input fbcr_pkg::result_t want,
                                    input fbcr_pkg::result_t got);
    fault_count++;
    if (fault_count <= FAULT_LOG_MAX)
      $display("%0t %s: want end=%0b data=%h %h %h adr=%h cmd=%h ok=%0b", $time, why,
               want.frame_end, want.data_first, want.data_second, want.data_third,
               want.frame_address, want.frame_command, want.check_ok);
    if (fault_count <= FAULT_LOG_MAX)
      $display("    got end=%0b data=%h %h %h adr=%h cmd=%h ok=%0b",
               got.frame_end, got.data_first, got.data_second, got.data_third,
               got.frame_address, got.frame_command, got.check_ok);
  endfunction

  function automatic fbcr_pkg::result_t status_item(input logic [7:0] a,
                                                    input logic [7:0] c,
                                                    input logic ok);
    fbcr_pkg::result_t r;
    r = '0;
    r.frame_end     = 1'b1;
    r.frame_address = a;
    r.frame_command = c;
    r.check_ok      = ok;
    return r;
  endfunction

  // monitor: config writes, result checks, prediction per accepted item
  always @(posedge clk) begin
    fbcr_pkg::result_t seen, nxt;
    bit                made;
    if (!rst_n) begin
      cfg_open  = fbcr_pkg::START_RST;
      cfg_close = fbcr_pkg::STOP_RST;
      cfg_base  = fbcr_pkg::OFFSET_RST;
      drop_frame();
      pending_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fbcr_pkg::CFG_START:  cfg_open  = cfg_wdata;
          fbcr_pkg::CFG_STOP:   cfg_close = cfg_wdata;
          fbcr_pkg::CFG_OFFSET: cfg_base  = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        seen = {out_frame_end, out_data_first, out_data_second, out_data_third,
                out_frame_address, out_frame_command, out_check_ok};
        if (pending_q.size() == 0) begin
          log_fault("unexpected item", '0, seen);
        end else begin
          nxt = pending_q.pop_front();
          if (seen !== nxt) log_fault("item mismatch", nxt, seen);
        end
      end
      if (in_valid && !in_stall) begin
        made = decode_line_byte(in_rx_byte, nxt);
        case (pin_kind)
          ROW_PREDICT: if (made) pending_q = {pending_q, nxt};
          ROW_GIVEN:   pending_q = {pending_q, pin_result};
          default: ;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver side: random stalls, plus a long hold-off on request
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served < hold_requests) begin
        holds_served++;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input row_kind_t kind,
                           input fbcr_pkg::result_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    pin_kind   <= kind;
    pin_result <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_line_codes(input logic [7:0] s, input logic [7:0] p,
                                 input logic [7:0] o);
    cfg_we    <= 1'b1;
    cfg_index <= fbcr_pkg::CFG_START;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_index <= fbcr_pkg::CFG_STOP;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_index <= fbcr_pkg::CFG_OFFSET;
    cfg_wdata <= o;
    @(posedge clk);
    cfg_we      <= 1'b0;
    line_start  = s;
    line_stop   = p;
    line_offset = o;
  endtask

  // mostly clean frames; some corrupted, truncated or unterminated; some noise
  task automatic emit_random_traffic(input int quota);
    int                         counted, pick, nchars, k;
    logic [fbcr_pkg::SUM_W-1:0] sum;
    logic [7:0]                 b, stopb;
    logic [5:0]                 v;
    counted = 0;
    while (counted < quota) begin
      pick = $urandom_range(0, 99);
      burst_q.delete();
      if (pick < 85) begin
        burst_q = {burst_q, line_start};
        sum = widen(line_start);
        repeat (2) begin
          do b = 8'($urandom); while (b == line_stop);
          burst_q = {burst_q, b};
          sum = sum + widen(b);
        end
        nchars = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(0, 16);
        if ($urandom_range(0, 1) == 1) nchars = nchars & ~3;
        repeat (nchars) begin
          do begin
            v = 6'($urandom);
            b = line_offset + 8'(v);
          end while (b == line_stop);
          burst_q = {burst_q, b};
          sum = sum + widen(b);
        end
        burst_q = {burst_q, line_offset + 8'(sum[11:6])};
        burst_q = {burst_q, line_offset + 8'(sum[5:0])};
        burst_q = {burst_q, line_stop};
        if (pick >= 70) begin
          case ($urandom_range(0, 2))
            0: burst_q[$urandom_range(1, burst_q.size() - 2)] = 8'($urandom);
            1: begin
              stopb = burst_q.pop_back();
              k = $urandom_range(1, burst_q.size() - 1);
              repeat (k) void'(burst_q.pop_back());
              burst_q = {burst_q, stopb};
            end
            default: void'(burst_q.pop_back());
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          k = $urandom_range(0, 7);
          b = (k == 0) ? line_stop : (k == 1) ? line_start : 8'($urandom);
          burst_q = {burst_q, b};
        end
      end
      counted += burst_q.size();
      foreach (burst_q[i]) send_byte(burst_q[i], ROW_PREDICT, '0);
    end
  endtask

  initial begin
    int seg, k;
    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= fbcr_pkg::CFG_START;
    cfg_wdata   <= '0;
    in_valid    <= 1'b0;
    in_rx_byte  <= '0;
    pin_kind    <= ROW_PREDICT;
    pin_result  <= '0;
    cycle_count = 0;
    fault_count = 0;
    hold_requests = 0;
    holds_served  = 0;
    send_idle_pct = 9;
    recv_idle_pct = 56;
    line_start  = fbcr_pkg::START_RST;
    line_stop   = fbcr_pkg::STOP_RST;
    line_offset = fbcr_pkg::OFFSET_RST;

    // reset-default codes: start 35, stop 13, offset 61.
    // A group item of three zero bytes is the all-zero item.
    dir_rows = '{
      '{8'd13,  ROW_SILENT,  '0},                              // stop while idle
      '{8'd35,  ROW_SILENT,  '0},
      '{8'hFF,  ROW_SILENT,  '0},
      '{8'd13,  ROW_GIVEN,   status_item(8'hFF, 8'h00, 1'b0)}, // no command
      '{8'd35,  ROW_SILENT,  '0},
      '{8'h00,  ROW_SILENT,  '0},
      '{8'hFF,  ROW_SILENT,  '0},
      '{8'd13,  ROW_GIVEN,   status_item(8'h00, 8'hFF, 1'b0)}, // no checksum
      // clean frame, start byte as command, all-ones payload
      '{8'd35,  ROW_PREDICT, '0},
      '{8'd1,   ROW_PREDICT, '0},
      '{8'd35,  ROW_PREDICT, '0},
      '{8'd124, ROW_PREDICT, '0},
      '{8'd124, ROW_PREDICT, '0},
      '{8'd124, ROW_PREDICT, '0},
      '{8'd124, ROW_PREDICT, '0},
      '{8'd69,  ROW_PREDICT, '0},
      '{8'd116, ROW_PREDICT, '0},
      '{8'd13,  ROW_PREDICT, '0},
      // negative address, zero payload, partial trailing group, bad checksum
      '{8'd35,  ROW_SILENT,  '0},
      '{8'hC8,  ROW_SILENT,  '0},
      '{8'h7F,  ROW_SILENT,  '0},
      '{8'd61,  ROW_SILENT,  '0},
      '{8'd61,  ROW_SILENT,  '0},
      '{8'd61,  ROW_SILENT,  '0},
      '{8'd61,  ROW_SILENT,  '0},
      '{8'd61,  ROW_SILENT,  '0},
      '{8'd61,  ROW_GIVEN,   '0},
      '{8'h00,  ROW_SILENT,  '0},
      '{8'd13,  ROW_GIVEN,   status_item(8'hC8, 8'h7F, 1'b0)}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send_byte(dir_rows[i].rx, dir_rows[i].kind, dir_rows[i].want);

    for (seg = 0; seg < 6; seg++) begin
      drain_results();
      if (seg == 2) begin
        send_idle_pct = 56;
        recv_idle_pct = 9;
      end
      if (seg == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (seg)
        0: load_line_codes(8'h3A, 8'h0A, 8'h30);
        1: load_line_codes(8'h00, 8'hFF, 8'h00);
        2: load_line_codes(8'hFF, 8'h00, 8'hFF);
        3: begin
          // start and stop share one code
          k = $urandom_range(0, 255);
          load_line_codes(8'(k), 8'(k), 8'($urandom));
        end
        4: load_line_codes(8'($urandom), 8'($urandom), 8'($urandom));
        default: load_line_codes(fbcr_pkg::START_RST, fbcr_pkg::STOP_RST,
                                 fbcr_pkg::OFFSET_RST);
      endcase
      if (seg == 1 || seg == 4) hold_requests++;
      emit_random_traffic(SEG_ITEMS);
    end
    drain_results();

    if (fault_count == 0 && pending_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

>>> framed_base64_checksum_receiver.f
hdl/fbcr_pkg.sv
hdl/framed_base64_checksum_receiver.sv
verif/tb.sv
